// File: design/cpp_pkg.sv
// shared types and constants for the command packet parser
package cpp_pkg;

  // field widths of the input and result words
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PAY_W     = 64;

  // configuration port
  localparam int CFG_W     = 64;
  localparam int REG_IDX_W = 2;
  localparam int SLOT_W    = 16;
  localparam int SLOT_BANKS = 3;
  localparam int SLOTS_PER_BANK = CFG_W / SLOT_W;
  localparam int SLOTS_MAX = SLOT_BANKS * SLOTS_PER_BANK;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CMD_SLOTS_A = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CMD_SLOTS_B = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CMD_SLOTS_C = 2'd3;

  // reset value of the start byte
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;

  // slot layout
  localparam int SLOT_VALID_BIT = 15;
  localparam int SLOT_LEN_LSB   = 8;
  localparam int SLOT_ID_LSB    = 0;

  // all slots of the table, slot k in bits 16k+15..16k
  typedef logic [SLOTS_MAX-1:0][SLOT_W-1:0] slot_tbl_t;

  // lookup answer for one command byte
  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len;
  } lkp_t;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_e;

endpackage

// File: design/cpp_if.sv
// valid/ready channels for received bytes and parsed commands

interface cpp_rx_if
  import cpp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpp_cmd_if
  import cpp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command_id;
  logic [LEN_W-1:0]  payload_length;
  logic [PAY_W-1:0]  payload_bytes;

  modport source (output valid, output command_id, output payload_length,
                  output payload_bytes, input ready);
  modport sink   (input valid, input command_id, input payload_length,
                  input payload_bytes, output ready);
endinterface

// File: design/cpp_cmd_lookup.sv
// parallel command table search, lowest valid matching slot wins
module cpp_cmd_lookup
  import cpp_pkg::*;
#(
  parameter int TABLE_SLOTS = 12,
  parameter int MAX_PAYLOAD = 8
) (
  input  slot_tbl_t         slots_i,
  input  logic [BYTE_W-1:0] id_i,
  output lkp_t              lkp_o
);

  logic [SLOT_W-1:0] slot;
  logic [LEN_W-1:0]  len;

  // walk from the top slot down so the lowest match is kept last
  always_comb begin
    lkp_o = '0;
    slot  = '0;
    len   = '0;
    for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
      slot = slots_i[k];
      len  = slot[SLOT_LEN_LSB +: LEN_W];
      if (len > LEN_W'(MAX_PAYLOAD)) begin
        len = LEN_W'(MAX_PAYLOAD);
      end
      if (slot[SLOT_VALID_BIT] && (slot[SLOT_ID_LSB +: BYTE_W] == id_i)) begin
        lkp_o.hit = 1'b1;
        lkp_o.len = len;
      end
    end
  end

endmodule

// File: design/command_packet_parser.sv
// command packet parser top level: start byte, command, payload, xor check
// result: a checksum word passes the input register, then the result register
// throughput: one received word per cycle; the input register stalls only when a
//   checksum word meets a result register that is still full and not being taken
// reset: asynchronous active low; parser returns to hunting, start byte 0xAA, table empty
module command_packet_parser
  import cpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 8,
  parameter int TABLE_SLOTS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cpp_rx_if.sink               rx_i,
  cpp_cmd_if.source            cmd_o
);

  localparam int PAYW  = MAX_PAYLOAD * BYTE_W;
  localparam int POS_W = $clog2(MAX_PAYLOAD);

  // configuration registers
  logic [BYTE_W-1:0] start_q;
  logic [CFG_W-1:0]  slots_a_q, slots_b_q, slots_c_q;

  // input register
  logic              in_vld_q;
  logic [BYTE_W-1:0] byte_q;

  // parser state
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [PAYW-1:0]   pay_q, pay_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  pos_inc;
  logic [BYTE_W-1:0] chk_q, chk_d;

  // result register
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_cmd_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [PAYW-1:0]   out_pay_q;

  logic      proc_go;
  logic      res_load;
  lkp_t      lkp;
  slot_tbl_t slot_tbl;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_BYTE_RST;
      slots_a_q <= '0;
      slots_b_q <= '0;
      slots_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_BYTE:  start_q   <= cfg_data_i[BYTE_W-1:0];
        REG_CMD_SLOTS_A: slots_a_q <= cfg_data_i;
        REG_CMD_SLOTS_B: slots_b_q <= cfg_data_i;
        REG_CMD_SLOTS_C: slots_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign slot_tbl = slot_tbl_t'({slots_c_q, slots_b_q, slots_a_q});

  // word in the input register moves on unless its result has nowhere to go
  assign proc_go  = in_vld_q && !(phase_q == PH_SUM && out_vld_q && !cmd_o.ready);
  assign rx_i.ready = !in_vld_q || proc_go;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  // command table search
  cpp_cmd_lookup #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_lookup (
    .slots_i (slot_tbl),
    .id_i    (byte_q),
    .lkp_o   (lkp)
  );

  assign pos_inc = pos_q + LEN_W'(1);

  // parser next state
  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    pay_d    = pay_q;
    pos_d    = pos_q;
    chk_d    = chk_q;
    res_load = 1'b0;
    if (proc_go) begin
      case (phase_q)
        PH_IDLE: begin
          if (byte_q == start_q) begin
            chk_d   = byte_q;
            pos_d   = '0;
            pay_d   = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          if (!lkp.hit) begin
            phase_d = PH_IDLE;
          end else begin
            cmd_d   = byte_q;
            len_d   = lkp.len;
            chk_d   = chk_q ^ byte_q;
            phase_d = (lkp.len == '0) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY: begin
          for (int k = 0; k < MAX_PAYLOAD; k++) begin
            if (pos_q[POS_W-1:0] == POS_W'(k)) begin
              pay_d[k*BYTE_W +: BYTE_W] = byte_q;
            end
          end
          pos_d = pos_inc;
          chk_d = chk_q ^ byte_q;
          if (pos_inc >= len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_d  = PH_IDLE;
          res_load = (byte_q == chk_q);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      len_q   <= '0;
      pay_q   <= '0;
      pos_q   <= '0;
      chk_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      pay_q   <= pay_d;
      pos_q   <= pos_d;
      chk_q   <= chk_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_cmd_q <= cmd_q;
      out_len_q <= len_q;
      out_pay_q <= pay_q;
    end
  end

  assign cmd_o.valid          = out_vld_q;
  assign cmd_o.command_id     = out_cmd_q;
  assign cmd_o.payload_length = out_len_q;
  assign cmd_o.payload_bytes  = PAY_W'(out_pay_q);

`ifndef SYNTH
  // a result is only loaded once the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_vld_q || cmd_o.ready))
    else $error("result register overwritten");

  // while collecting payload the position stays below the expected length
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (pos_q < len_q))
    else $error("payload position out of range");

  // a delivered length never exceeds the payload storage
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_len_q <= LEN_W'(MAX_PAYLOAD)))
    else $error("result length above maximum payload");

  // a result appears only after a checksum word was processed
  a_res_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(proc_go && phase_q == PH_SUM))
    else $error("result without checksum word");
`endif

endmodule
